@@ hdl/scfla_pkg.sv @@
// Shared types, constants and helper functions for the size-class allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package scfla_pkg;

  localparam int unsigned AlignBytes    = 8;
  localparam int unsigned MaxSmallBytes = 128;
  localparam int unsigned NumClasses    = 16;
  localparam int unsigned RefillBlocks  = 20;
  localparam int unsigned ArenaBytes    = 65536;
  localparam int unsigned LinkDepth     = ArenaBytes / AlignBytes;
  localparam int unsigned AlignShift    = $clog2(AlignBytes);
  localparam int unsigned ClassW        = $clog2(NumClasses);
  localparam int unsigned SlotW         = $clog2(LinkDepth);
  localparam int unsigned CountW        = $clog2(RefillBlocks + 1);
  localparam int unsigned AddrW         = 16;
  localparam int unsigned WideW         = 17;
  localparam logic [AddrW-1:0] EmptyMark = '1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_DEALLOC = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_RELEASED  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_NO_MEMORY = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REL_PUSH,
    S_ALLOC_CHK,
    S_POP_RD,
    S_POP_WAIT,
    S_POP_DONE,
    S_SPILL,
    S_GROW,
    S_SCAN,
    S_BOR_RD,
    S_BOR_WAIT,
    S_BOR_DONE,
    S_DIV,
    S_CARVE,
    S_LINK,
    S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_REL_PUSH,
    OP_ALLOC_CHK,
    OP_POP_RD,
    OP_POP_DONE,
    OP_SPILL,
    OP_GROW,
    OP_SCAN_STEP,
    OP_BOR_RD,
    OP_BOR_DONE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CARVE,
    OP_LINK,
    OP_OOM,
    OP_DONE_TOO_LARGE
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic    is_alloc;
    logic    is_release;
    logic    rel_too_large;
    logic    alloc_too_large;
    logic    head_empty;
    logic    pool_short;
    logic    left_nonzero;
    logic    grow_fits;
    logic    scan_hit;
    logic    scan_end;
    logic    div_done;
    logic    carve_links;
    logic    link_last;
  } dp_status_t;

  function automatic logic [ClassW-1:0] class_of(input logic [WideW-1:0] size);
    logic [WideW-1:0] c;
    c = (size == '0) ? '0 : ((size - WideW'(1)) >> AlignShift);
    if (c >= WideW'(NumClasses)) c = WideW'(NumClasses - 1);
    return c[ClassW-1:0];
  endfunction

  function automatic logic [SlotW-1:0] slot_of(input logic [AddrW-1:0] a);
    return a[AlignShift +: SlotW];
  endfunction

endpackage

@@ hdl/scfla_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module scfla_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/scfla_datapath.sv @@
// Datapath of the allocator: list heads, pool bounds, link memory and divider.
// Depends on scfla_pkg and scfla_ram.
module scfla_datapath
  import scfla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [1:0]       in_cmd_i,
  input  logic [11:0]      in_size_i,
  input  logic [11:0]      in_old_size_i,
  input  logic [AddrW-1:0] in_addr_i,
  output dp_status_t       status_o,
  output logic [AddrW-1:0] result_addr_o,
  output logic [1:0]       result_status_o
);

  logic [AddrW-1:0]  heads_q [NumClasses];
  logic [WideW-1:0]  pool_start_q, pool_end_q, heap_used_q;
  logic [1:0]        cmd_q;
  logic [11:0]       size_q, old_size_q;
  logic [AddrW-1:0]  blk_q;
  logic [ClassW-1:0] cls_q, scan_q;
  logic [WideW-1:0]  bytes_q, total_q, left_q;
  logic [WideW-1:0]  rem_q;
  logic [CountW-1:0] n_q, k_q;
  logic [WideW-1:0]  link_addr_q;
  logic [AddrW-1:0]  res_addr_q;
  logic [1:0]        res_status_q;

  logic             ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [AddrW-1:0] ram_wdata, ram_rdata;

  logic [WideW-1:0] left_now, grow_now, heap_rnd, next_addr;
  logic [ClassW-1:0] alloc_cls;

  scfla_ram #(.Width(AddrW), .Depth(LinkDepth)) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign alloc_cls = class_of(WideW'(size_q));
  assign left_now  = (pool_end_q >= pool_start_q) ? pool_end_q - pool_start_q : '0;
  assign heap_rnd  = (((heap_used_q >> 4) + WideW'(AlignBytes - 1)) >> AlignShift)
                     << AlignShift;
  assign grow_now  = (total_q << 1) + heap_rnd;
  assign next_addr = link_addr_q + bytes_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(blk_q);
    ram_wdata = heads_q[class_of(WideW'(old_size_q))];
    ram_raddr = slot_of(heads_q[cls_q]);
    case (cmd_i.op)
      OP_REL_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(blk_q);
        ram_wdata = (cmd_q == CMD_DEALLOC) ? heads_q[class_of(WideW'(size_q))]
                                           : heads_q[class_of(WideW'(old_size_q))];
      end
      OP_SPILL: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(pool_start_q[AddrW-1:0]);
        ram_wdata = heads_q[class_of(left_q)];
      end
      OP_BOR_RD: ram_raddr = slot_of(heads_q[scan_q]);
      OP_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(link_addr_q[AddrW-1:0]);
        ram_wdata = (k_q == n_q - CountW'(1)) ? EmptyMark : next_addr[AddrW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumClasses; i++) heads_q[i] <= EmptyMark;
      pool_start_q <= '0;
      pool_end_q   <= '0;
      heap_used_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_REL_PUSH: begin
          if (cmd_q == CMD_DEALLOC) heads_q[class_of(WideW'(size_q))] <= blk_q;
          else heads_q[class_of(WideW'(old_size_q))] <= blk_q;
        end
        OP_POP_DONE: heads_q[cls_q] <= ram_rdata;
        OP_SPILL: heads_q[class_of(left_q)] <= pool_start_q[AddrW-1:0];
        OP_GROW: begin
          pool_start_q <= heap_used_q;
          heap_used_q  <= heap_used_q + grow_now;
          pool_end_q   <= heap_used_q + grow_now;
        end
        OP_BOR_DONE: begin
          heads_q[scan_q] <= ram_rdata;
          pool_start_q    <= WideW'(heads_q[scan_q]);
          pool_end_q      <= WideW'(heads_q[scan_q])
                             + ((WideW'(scan_q) + WideW'(1)) << AlignShift);
        end
        OP_OOM: begin
          pool_start_q <= '0;
          pool_end_q   <= '0;
        end
        OP_CARVE: begin
          pool_start_q <= pool_start_q + WideW'(n_q) * bytes_q;
          if (n_q > CountW'(1)) begin
            heads_q[cls_q] <= pool_start_q[AddrW-1:0] + bytes_q[AddrW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        cmd_q      <= in_cmd_i;
        size_q     <= in_size_i;
        old_size_q <= in_old_size_i;
        blk_q      <= in_addr_i;
      end
      OP_REL_PUSH: begin
        res_status_q <= ST_RELEASED;
        res_addr_q   <= '0;
      end
      OP_DONE_TOO_LARGE: begin
        res_status_q <= ST_TOO_LARGE;
        res_addr_q   <= '0;
      end
      OP_ALLOC_CHK: begin
        cls_q   <= alloc_cls;
        scan_q  <= alloc_cls;
        bytes_q <= (WideW'(alloc_cls) + WideW'(1)) << AlignShift;
        total_q <= ((WideW'(alloc_cls) + WideW'(1)) << AlignShift) * WideW'(RefillBlocks);
        left_q  <= left_now;
      end
      OP_POP_DONE: begin
        res_addr_q   <= heads_q[cls_q];
        res_status_q <= ST_ALLOCATED;
      end
      OP_SCAN_STEP: scan_q <= scan_q + ClassW'(1);
      OP_OOM: begin
        res_addr_q   <= '0;
        res_status_q <= ST_NO_MEMORY;
      end
      OP_DIV_INIT: begin
        left_q <= left_now;
        rem_q  <= left_now;
        n_q    <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_q >= bytes_q && n_q != CountW'(RefillBlocks)) begin
          rem_q <= rem_q - bytes_q;
          n_q   <= n_q + CountW'(1);
        end
      end
      OP_CARVE: begin
        link_addr_q  <= pool_start_q + bytes_q;
        k_q          <= CountW'(1);
        res_addr_q   <= pool_start_q[AddrW-1:0];
        res_status_q <= ST_ALLOCATED;
      end
      OP_LINK: begin
        link_addr_q <= next_addr;
        k_q         <= k_q + CountW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.is_alloc        = (cmd_q == CMD_ALLOC) || (cmd_q == CMD_REALLOC);
    status_o.is_release      = (cmd_q == CMD_DEALLOC) || (cmd_q == CMD_REALLOC);
    status_o.rel_too_large   = (cmd_q == CMD_DEALLOC)
                               ? (size_q > 12'(MaxSmallBytes))
                               : (old_size_q > 12'(MaxSmallBytes));
    status_o.alloc_too_large = size_q > 12'(MaxSmallBytes);
    status_o.head_empty      = heads_q[alloc_cls] == EmptyMark;
    status_o.pool_short      = left_q < bytes_q;
    status_o.left_nonzero    = left_q != '0;
    status_o.grow_fits       = (heap_used_q <= WideW'(ArenaBytes))
                               && ({1'b0, grow_now} <= ({1'b0, WideW'(ArenaBytes)}
                               - {1'b0, heap_used_q}));
    status_o.scan_hit        = heads_q[scan_q] != EmptyMark;
    status_o.scan_end        = scan_q == ClassW'(NumClasses - 1);
    status_o.div_done        = (rem_q < bytes_q) || (n_q == CountW'(RefillBlocks));
    status_o.carve_links     = n_q > CountW'(1);
    status_o.link_last       = k_q == n_q - CountW'(1);
  end

  assign result_addr_o   = res_addr_q;
  assign result_status_o = res_status_q;

endmodule

@@ hdl/scfla_ctrl.sv @@
// Controller state machine of the allocator: sequences release, pop, refill,
// growth and borrowing. Depends on scfla_pkg.
module scfla_ctrl
  import scfla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   div_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_REL_PUSH;
      S_REL_PUSH: begin
        if (!status_i.is_alloc && !status_i.is_release) state_d = S_OUT;
        else if (!status_i.is_alloc) state_d = S_OUT;
        else state_d = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (status_i.alloc_too_large) state_d = S_OUT;
        else if (!status_i.head_empty) state_d = S_POP_RD;
        else state_d = S_SPILL;
      end
      S_POP_RD:   state_d = S_POP_WAIT;
      S_POP_WAIT: state_d = S_POP_DONE;
      S_POP_DONE: state_d = S_OUT;
      S_SPILL: begin
        if (!status_i.pool_short) state_d = S_DIV;
        else if (status_i.grow_fits) state_d = S_GROW;
        else state_d = S_SCAN;
      end
      S_GROW: state_d = S_DIV;
      S_SCAN: begin
        if (status_i.scan_hit) state_d = S_BOR_RD;
        else if (status_i.scan_end) state_d = S_OUT;
        else state_d = S_SCAN;
      end
      S_BOR_RD:   state_d = S_BOR_WAIT;
      S_BOR_WAIT: state_d = S_BOR_DONE;
      S_BOR_DONE: state_d = S_DIV;
      S_DIV:      if (!div_first_q && status_i.div_done) state_d = S_CARVE;
      S_CARVE:    state_d = status_i.carve_links ? S_LINK : S_OUT;
      S_LINK:     if (status_i.link_last) state_d = S_OUT;
      S_OUT:      if (out_ready_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Entering S_DIV from spill, growth or borrowing loads the divider first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_first_q <= 1'b0;
    else div_first_q <= (state_d == S_DIV) && (state_q != S_DIV);
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.op   = OP_LATCH;
      end
      S_REL_PUSH: begin
        if (!status_i.is_alloc && !status_i.is_release) cmd_o.op = OP_DONE_TOO_LARGE;
        else if (status_i.is_release && status_i.rel_too_large) begin
          cmd_o.op = status_i.is_alloc ? OP_NONE : OP_DONE_TOO_LARGE;
        end else if (status_i.is_release) cmd_o.op = OP_REL_PUSH;
      end
      S_ALLOC_CHK: begin
        cmd_o.op = status_i.alloc_too_large ? OP_DONE_TOO_LARGE : OP_ALLOC_CHK;
      end
      S_POP_RD:   cmd_o.op = OP_POP_RD;
      S_POP_DONE: cmd_o.op = OP_POP_DONE;
      S_SPILL: begin
        if (status_i.pool_short && status_i.left_nonzero) cmd_o.op = OP_SPILL;
      end
      S_GROW: cmd_o.op = OP_GROW;
      S_SCAN: begin
        if (!status_i.scan_hit) begin
          cmd_o.op = status_i.scan_end ? OP_OOM : OP_SCAN_STEP;
        end
      end
      S_BOR_RD, S_BOR_WAIT: cmd_o.op = OP_BOR_RD;
      S_BOR_DONE: cmd_o.op = OP_BOR_DONE;
      S_DIV:      cmd_o.op = div_first_q ? OP_DIV_INIT : OP_DIV_STEP;
      S_CARVE:    cmd_o.op = OP_CARVE;
      S_LINK:     cmd_o.op = OP_LINK;
      S_OUT:      out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD) |=> (state_q == S_POP_WAIT))
    else $error("pop read not followed by wait");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted with result pending");

endmodule

@@ hdl/size_class_free_list_allocator_unit.sv @@
// Size-class free-list allocator: one item in, one result item out.
// A release passes the release push state; a pop the allocation check, the link read,
// its wait and the head update; a refill spills a short pool, grows it or borrows by
// scanning the classes, then divides, carves and links each block after the first.
// One item is in work at a time; the next can be accepted the cycle after the result leaves.
// Reset is asynchronous and active low; list heads read empty, pool and arena zero.
module size_class_free_list_allocator_unit
  import scfla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // size_bytes, old_size_bytes, block_addr
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // result_addr
  output logic [1:0]  m_axis_tuser   // status
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  scfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  scfla_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .in_cmd_i        (s_axis_tuser),
    .in_size_i       (s_axis_tdata[11:0]),
    .in_old_size_i   (s_axis_tdata[23:12]),
    .in_addr_i       (s_axis_tdata[39:24]),
    .status_o        (dp_status),
    .result_addr_o   (m_axis_tdata),
    .result_status_o (m_axis_tuser)
  );

endmodule
